// ===== rtl/core/pans_pkg.sv =====
// Package for the pool active node selector.
// Holds shared constants, configuration register indexes and the
// command and status structs between the controller and the datapath.
package pans_pkg;

  // Width of the node masks and of the counts carried on the ports.
  localparam int NODE_W      = 32;
  localparam int NODE_IDX_W  = $clog2(NODE_W);
  localparam int CNT_W       = 6;

  // Default node limit of the pool.
  localparam int MAX_NODES_DEF = 32;

  // Live-node counting is done a chunk of lanes per cycle.
  localparam int COUNT_LANES = 8;
  localparam int COUNT_STEPS = NODE_W / COUNT_LANES;
  localparam int CSTEP_W     = $clog2(COUNT_STEPS);

  // Configuration register port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_FLOOR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_POLICY = 1'd1;

  typedef struct packed {
    logic                  take_in;
    logic                  enroll;
    logic                  count_en;
    logic [CSTEP_W-1:0]    count_sel;
    logic                  decide;
    logic                  fill_en;
    logic [NODE_IDX_W-1:0] fill_sel;
    logic                  emit;
  } pans_cmd_t;

  typedef struct packed {
    logic do_fill;
  } pans_status_t;

endpackage

// ===== rtl/core/pans_datapath.sv =====
// Datapath of the pool active node selector: configuration, pool state,
// live-node counting and the index-ordered fill. Depends on pans_pkg.
module pans_datapath #(
  parameter int MAX_NODES = pans_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pans_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pans_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           kind,
  input  logic [pans_pkg::NODE_W-1:0]     up_mask,
  input  logic [pans_pkg::NODE_W-1:0]     downtime_mask,
  input  pans_pkg::pans_cmd_t            cmd,
  output pans_pkg::pans_status_t         status,
  output logic [pans_pkg::NODE_W-1:0]     active_mask,
  output logic                           pool_up,
  output logic [pans_pkg::CNT_W-1:0]      alive_count,
  output logic [pans_pkg::CNT_W-1:0]      active_count
);
  import pans_pkg::*;

  localparam int NODE_LIMIT = (MAX_NODES > NODE_W) ? NODE_W : MAX_NODES;
  localparam int ENR_W      = $clog2(NODE_LIMIT + 1);

  function automatic logic [CNT_W-1:0] count_ones8(input logic [COUNT_LANES-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < COUNT_LANES; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  // Configuration registers.
  logic [CNT_W-1:0] node_floor;
  logic             force_fill;

  // Pool state.
  logic [ENR_W-1:0]  enrolled_count;
  logic [NODE_W-1:0] enr_mask;
  logic [NODE_W-1:0] active_set;

  // Latched request.
  logic              kind_r;
  logic [NODE_W-1:0] up_r;
  logic [NODE_W-1:0] down_r;

  // Working registers of one evaluation.
  logic [CNT_W-1:0]  alive_acc;
  logic [CNT_W-1:0]  cand_acc;
  logic [CNT_W-1:0]  rem1;
  logic [CNT_W-1:0]  rem2;
  logic [CNT_W-1:0]  act_cnt;
  logic [NODE_W-1:0] work_set;
  logic              pool_up_w;

  logic [NODE_IDX_W-1:0] enr_idx;
  logic                  room;
  logic [NODE_W-1:0]     live;
  logic [NODE_W-1:0]     cand1;
  logic [NODE_W-1:0]     cand2;
  logic [COUNT_STEPS-1:0][COUNT_LANES-1:0] live_chunks;
  logic [COUNT_STEPS-1:0][COUNT_LANES-1:0] cand_chunks;
  logic             enough;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] take1;

  assign enr_idx = NODE_IDX_W'(enrolled_count);
  assign room    = enrolled_count < ENR_W'(NODE_LIMIT);
  assign live    = up_r & enr_mask;
  // Previously active candidates, then any enrolled candidate, both outside
  // scheduled downtime and not already live.
  assign cand1   = active_set & enr_mask & ~down_r & ~live;
  assign cand2   = enr_mask & ~down_r & ~live;
  assign live_chunks = live;
  assign cand_chunks = cand1;

  assign enough = alive_acc >= node_floor;
  assign need   = node_floor - alive_acc;
  assign take1  = (need < cand_acc) ? need : cand_acc;

  assign status.do_fill = force_fill && !enough;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_floor <= '0;
      force_fill <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_FLOOR:  node_floor <= cfg_data;
        CFG_FILL_POLICY: force_fill <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enrolled_count <= '0;
      enr_mask       <= '0;
      active_set     <= '0;
    end else if (cmd.enroll && kind_r && room) begin
      enrolled_count    <= enrolled_count + 1'b1;
      enr_mask[enr_idx] <= 1'b1;
      if (up_r[enr_idx]) begin
        active_set[enr_idx] <= 1'b1;
      end
    end else if (cmd.emit) begin
      active_set <= work_set;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      kind_r    <= kind;
      up_r      <= up_mask;
      down_r    <= downtime_mask;
      alive_acc <= '0;
      cand_acc  <= '0;
    end
    if (cmd.count_en) begin
      alive_acc <= alive_acc + count_ones8(live_chunks[cmd.count_sel]);
      cand_acc  <= cand_acc + count_ones8(cand_chunks[cmd.count_sel]);
    end
    if (cmd.decide) begin
      pool_up_w <= enough || force_fill;
      work_set  <= (enough || force_fill) ? live : '0;
      act_cnt   <= (enough || force_fill) ? alive_acc : '0;
      rem1      <= enough ? '0 : take1;
      rem2      <= enough ? '0 : need - take1;
    end
    if (cmd.fill_en) begin
      if (cand1[cmd.fill_sel] && rem1 != '0) begin
        work_set[cmd.fill_sel] <= 1'b1;
        rem1    <= rem1 - 1'b1;
        act_cnt <= act_cnt + 1'b1;
      end else if (cand2[cmd.fill_sel] && rem2 != '0) begin
        work_set[cmd.fill_sel] <= 1'b1;
        rem2    <= rem2 - 1'b1;
        act_cnt <= act_cnt + 1'b1;
      end
    end
    if (cmd.emit) begin
      active_mask  <= work_set;
      pool_up      <= pool_up_w;
      alive_count  <= alive_acc;
      active_count <= act_cnt;
    end
  end

endmodule

// ===== rtl/core/pans_ctrl.sv =====
// Controller of the pool active node selector: sequences enrolment,
// counting, decision, fill and result hand-over. Depends on pans_pkg.
module pans_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pans_pkg::pans_cmd_t    cmd,
  input  pans_pkg::pans_status_t status
);
  import pans_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ENROLL = 6'b000010,
    S_COUNT  = 6'b000100,
    S_DECIDE = 6'b001000,
    S_FILL   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [CSTEP_W-1:0]    count_idx;
  logic [NODE_IDX_W-1:0] fill_idx;
  logic                  out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.take_in   = (state == S_IDLE) && in_valid;
    cmd.enroll    = (state == S_ENROLL);
    cmd.count_en  = (state == S_COUNT);
    cmd.count_sel = count_idx;
    cmd.decide    = (state == S_DECIDE);
    cmd.fill_en   = (state == S_FILL);
    cmd.fill_sel  = fill_idx;
    cmd.emit      = (state == S_EMIT) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_ENROLL;
      end
      S_ENROLL: state_next = S_COUNT;
      S_COUNT: begin
        if (count_idx == CSTEP_W'(COUNT_STEPS - 1)) state_next = S_DECIDE;
      end
      S_DECIDE: state_next = status.do_fill ? S_FILL : S_EMIT;
      S_FILL: begin
        if (fill_idx == NODE_IDX_W'(NODE_W - 1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_idx <= '0;
      fill_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count_idx <= (state == S_COUNT) ? count_idx + 1'b1 : '0;
      fill_idx  <= (state == S_FILL) ? fill_idx + 1'b1 : '0;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/pool_active_node_selector_top.sv =====
// Top level of the pool active node selector.
// Joins pans_ctrl and pans_datapath; depends on pans_pkg.
//
// Usage. Each request on the input channel (in_valid, in_stall) carries a
// kind, the up bits and the scheduled-downtime bits of all nodes. A request
// of the add kind first enrols the next node of the pool if there is room.
// The block then counts the live enrolled nodes and chooses the new active
// set, giving one result request on the output channel (out_valid, out_stall).
// Sequence: after a request is taken come the enrolment state, the counting
// state (eight nodes per cycle) and the decision state. When the pool is
// short of nodes under force-up, a fill scan walks all 32 node indexes, one
// per cycle. The emit state then loads the output register, waiting while a
// held result is stalled; only then can the next request be taken.
// One request is worked on at a time; in_stall is high from acceptance
// until the result has entered the output register.
// A result held by a stalled receiver stays in the output register, and the
// next request may already be accepted and evaluated behind it.
// Reset clears the configuration, the enrolled nodes and the active set.
// The user writes configuration through cfg_we, cfg_index and cfg_data only
// while idle; the block itself does not enforce this.
module pool_active_node_selector_top #(
  parameter int MAX_NODES = pans_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pans_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pans_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [pans_pkg::NODE_W-1:0]     up_mask,
  input  logic [pans_pkg::NODE_W-1:0]     downtime_mask,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pans_pkg::NODE_W-1:0]     active_mask,
  output logic                           pool_up,
  output logic [pans_pkg::CNT_W-1:0]      alive_count,
  output logic [pans_pkg::CNT_W-1:0]      active_count
);
  import pans_pkg::*;

  pans_cmd_t    cmd;
  pans_status_t status;

  // The controller sequences one request at a time and owns the handshakes.
  pans_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the configuration, the pool state and the result.
  pans_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .up_mask       (up_mask),
    .downtime_mask (downtime_mask),
    .cmd           (cmd),
    .status        (status),
    .active_mask   (active_mask),
    .pool_up       (pool_up),
    .alive_count   (alive_count),
    .active_count  (active_count)
  );

  // Once a request is taken, no further request is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in progress");

  // A pool that is down has an empty active set.
  a_down_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pool_up) |-> (active_mask == '0 && active_count == '0))
    else $error("pool down with active nodes");

  // A pool that is up has no fewer active nodes than live nodes.
  a_up_keeps_live: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pool_up) |-> (active_count >= alive_count))
    else $error("active set smaller than the live nodes");

  // The result register is only reloaded when the previous result has gone.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (cmd.emit == 1'b0 || $past(cmd.emit) == 1'b0))
    else $error("result overwritten while stalled");

endmodule
